>>> design/spq_pkg.sv
// Shared types for the stable priority queue: request and response
// transactions, opcode and status codes, and the cell control group.
// No dependencies.
package spq_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_PEEK   = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [31:0]        entry_tag;
        logic signed [15:0] entry_priority;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        head_tag;
        logic signed [15:0] head_priority;
        logic [4:0]         entry_count;
    } rsp_t;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic insert;
        logic remove;
    } cell_ctl_t;

endpackage

>>> design/stable_priority_queue_core.sv
// Stable bounded priority queue built as a chain of sorting cells.
// Depends on spq_pkg and spq_cell.
//
// Channel   Valid      Stall      Payload   Direction
// request   req_valid  req_stall  req       in   (opcode, tag, priority)
// response  rsp_valid  rsp_stall  rsp       out  (status, head, count)
//
// One transaction per cycle unless a stalled response blocks it: the whole
// chain compares the new priority in parallel and shifts in the accept
// cycle; the response appears the next cycle from the output register.
// Reset clears the entry count and the response valid; slot contents are
// not reset. A stalled response holds and blocks only the next request.
module stable_priority_queue_core
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                rsp_valid_reg;
    rsp_t                rsp_reg;
    rsp_t                rsp_next;
    cell_ctl_t           ctl;
    logic                accept;
    logic [TAG_BITS+31:0] new_tag_ext;
    logic [TAG_BITS-1:0] new_tag;
    logic [TAG_BITS+31:0] head_tag_ext;
    logic [CW+4:0]       count_ext;

    logic signed [15:0]  prio_w   [QUEUE_DEPTH];
    logic [TAG_BITS-1:0] tag_w    [QUEUE_DEPTH];
    logic                before_w [QUEUE_DEPTH];

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    assign new_tag_ext  = {{TAG_BITS{1'b0}}, req.entry_tag};
    assign new_tag      = new_tag_ext[TAG_BITS-1:0];
    assign head_tag_ext = {32'd0, tag_w[0]};
    assign count_ext    = {5'd0, count_next};

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            logic                occ;
            logic                lb;
            logic signed [15:0]  lp;
            logic [TAG_BITS-1:0] lt;
            logic signed [15:0]  rp;
            logic [TAG_BITS-1:0] rt;

            assign occ = count_reg > CW'(i);

            if (i == 0)
            begin : g_head
                assign lb = 1'b0;
                assign lp = req.entry_priority;
                assign lt = new_tag;
            end
            else
            begin : g_mid
                assign lb = before_w[i-1];
                assign lp = prio_w[i-1];
                assign lt = tag_w[i-1];
            end

            if (i == QUEUE_DEPTH - 1)
            begin : g_tail
                assign rp = prio_w[i];
                assign rt = tag_w[i];
            end
            else
            begin : g_body
                assign rp = prio_w[i+1];
                assign rt = tag_w[i+1];
            end

            spq_cell #(
                .TAG_BITS (TAG_BITS)
            ) u_cell (
                .clk            (clk),
                .ctl            (ctl),
                .new_priority   (req.entry_priority),
                .new_tag        (new_tag),
                .occupied       (occ),
                .left_before    (lb),
                .left_priority  (lp),
                .left_tag       (lt),
                .right_priority (rp),
                .right_tag      (rt),
                .priority_out   (prio_w[i]),
                .tag_out        (tag_w[i]),
                .ahead          (before_w[i])
            );
        end
    endgenerate

    // Decode the request, steer the chain and build the response
    always_comb
    begin
        ctl                    = '0;
        count_next             = count_reg;
        rsp_next               = '0;
        rsp_next.status        = ST_OK;
        if (accept)
        begin
            case (req.opcode)
                OP_INSERT:
                begin
                    if (count_reg == CW'(QUEUE_DEPTH))
                    begin
                        rsp_next.status = ST_FULL;
                    end
                    else
                    begin
                        ctl.insert = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                OP_REMOVE, OP_PEEK:
                begin
                    if (count_reg == '0)
                    begin
                        rsp_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        rsp_next.head_tag      = head_tag_ext[31:0];
                        rsp_next.head_priority = prio_w[0];
                        if (req.opcode == OP_REMOVE)
                        begin
                            ctl.remove = 1'b1;
                            count_next = count_reg - CW'(1);
                        end
                    end
                end
                default:
                begin
                    rsp_next.status = ST_OK;
                end
            endcase
        end
        rsp_next.entry_count = count_ext[4:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the response until taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> design/spq_cell.sv
// One slot of the sorted chain: holds a priority and a tag, and on each
// command either keeps them, shifts from a neighbour or takes the new entry.
// Depends on spq_pkg.
module spq_cell
    import spq_pkg::*;
#(
    parameter int TAG_BITS = 32
)
(
    input  logic                clk,
    input  cell_ctl_t           ctl,
    input  logic signed [15:0]  new_priority,
    input  logic [TAG_BITS-1:0] new_tag,
    input  logic                occupied,
    input  logic                left_before,
    input  logic signed [15:0]  left_priority,
    input  logic [TAG_BITS-1:0] left_tag,
    input  logic signed [15:0]  right_priority,
    input  logic [TAG_BITS-1:0] right_tag,
    output logic signed [15:0]  priority_out,
    output logic [TAG_BITS-1:0] tag_out,
    output logic                ahead
);

    logic signed [15:0]  priority_reg;
    logic signed [15:0]  priority_next;
    logic [TAG_BITS-1:0] tag_reg;
    logic [TAG_BITS-1:0] tag_next;

    // New entry goes ahead of this slot only on strictly greater priority,
    // so equal priorities keep arrival order.
    assign ahead = !occupied || (new_priority > priority_reg);

    always_comb
    begin
        priority_next = priority_reg;
        tag_next      = tag_reg;
        if (ctl.insert && ahead)
        begin
            if (left_before)
            begin
                priority_next = left_priority;
                tag_next      = left_tag;
            end
            else
            begin
                priority_next = new_priority;
                tag_next      = new_tag;
            end
        end
        else if (ctl.remove)
        begin
            priority_next = right_priority;
            tag_next      = right_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        priority_reg <= priority_next;
        tag_reg      <= tag_next;
    end

    assign priority_out = priority_reg;
    assign tag_out      = tag_reg;

endmodule
